>>> rtl/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared types and constants for the vector norm block: norm kinds,
// sequencer states, and the request word for the shared add/subtract unit.
// ----------------------------------------------------------------------------
package vnorm_pkg;

    localparam int ELEM_W  = 32;
    localparam int SUM_W   = 64;
    localparam int NORM_W  = 48;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int CNT_W   = $clog2(ROOT_W);
    localparam int REM_W   = ROOT_W + 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [NORM_W-1:0] NORM_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    typedef enum logic [1:0] {
        KIND_L1   = 2'd0,
        KIND_L2   = 2'd1,
        KIND_LINF = 2'd2,
        KIND_ZERO = 2'd3
    } t_norm_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_ACC,
        ST_ROOT,
        ST_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } t_alu_req;

endpackage

>>> rtl/vector_norm_l1_l2_linf.sv
// ----------------------------------------------------------------------------
// vector_norm_l1_l2_linf
// Streaming L1 / L2 / L-infinity norm of a signed Q16.16 vector, one
// unsigned Q32.16 result word per vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one element word per
//   vector element; i_is_last closes the vector. Output channel
//   (o_out_valid / i_out_stall) delivers one norm word per vector.
//   Norm kind is set through the APB port (address 0) while idle.
// Sequence:
//   Each element is captured, turned into a term (its square for L2, else
//   its magnitude) and accumulated; only accumulation uses the shared unit,
//   and o_in_stall is high until the sequencer is idle again. After a last
//   element the square root runs for L2 (one root bit per cycle on the shared
//   unit), then the done state loads the output register once it is free.
// Reset: accumulator, saturation flag and output valid clear; kind is L2.
// Stall: the result word is held in the output register; the next element
//   is still taken, and a further result waits in the sequencer until the
//   output register frees.
// ----------------------------------------------------------------------------
module vector_norm_l1_l2_linf (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vnorm_pkg::APB_AW-1:0]   paddr,
    input  logic [vnorm_pkg::APB_DW-1:0]   pwdata,
    output logic [vnorm_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [vnorm_pkg::ELEM_W-1:0] i_element_value,
    input  logic                           i_is_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vnorm_pkg::NORM_W-1:0]   o_norm_value,
    output logic                           o_overflow
);
    import vnorm_pkg::*;

    t_norm_kind w_kind;
    t_alu_req   w_alu_req;
    logic [SUM_W:0] w_alu_res;

    t_state               r_state,     n_state;
    logic [SUM_W-1:0]     r_sum,       n_sum;
    logic                 r_sat,       n_sat;
    logic                 r_out_valid, n_out_valid;
    logic [ELEM_W-1:0]    r_mag,       n_mag;
    logic                 r_last,      n_last;
    logic [SUM_W-1:0]     r_term,      n_term;
    logic [REM_W-1:0]     r_rem,       n_rem;
    logic [ROOT_W-1:0]    r_root,      n_root;
    logic [CNT_W-1:0]     r_cnt,       n_cnt;
    logic [NORM_W-1:0]    r_norm,      n_norm;
    logic                 r_ovf,       n_ovf;

    logic [SUM_W-1:0]     w_sq;
    logic [REM_W-1:0]     w_rem_sh;
    logic [REM_W-1:0]     w_trial;
    logic                 w_out_free;

    vnorm_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_norm_kind (w_kind)
    );

    vnorm_alu u_alu (
        .i_req    (w_alu_req),
        .o_result (w_alu_res)
    );

    assign w_sq       = SUM_W'(r_mag) * SUM_W'(r_mag);
    assign w_rem_sh   = {r_rem[ROOT_W-1:0], r_sum[{r_cnt, 1'b1}], r_sum[{r_cnt, 1'b0}]};
    assign w_trial    = {r_root, 2'b01};
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_last <= n_last;
        r_term <= n_term;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        r_norm <= n_norm;
        r_ovf  <= n_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        n_mag       = r_mag;
        n_last      = r_last;
        n_term      = r_term;
        n_rem       = r_rem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_norm      = r_norm;
        n_ovf       = r_ovf;

        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = r_sum;
        w_alu_req.b  = r_term;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mag   = i_element_value[ELEM_W-1] ? (ELEM_W'(0) - i_element_value)
                                                        : i_element_value;
                    n_last  = i_is_last;
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                n_term  = (w_kind == KIND_L2) ? w_sq : SUM_W'(r_mag);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                unique case (w_kind)
                    KIND_L1: begin
                        if ((r_sum[SUM_W-1:NORM_W] != '0) || (w_alu_res[SUM_W:NORM_W] != '0)) begin
                            n_sum = SUM_W'(NORM_MAX);
                            n_sat = 1'b1;
                        end else begin
                            n_sum = w_alu_res[SUM_W-1:0];
                        end
                    end
                    KIND_L2: begin
                        if (w_alu_res[SUM_W]) begin
                            n_sum = SUM_MAX;
                            n_sat = 1'b1;
                        end else begin
                            n_sum = w_alu_res[SUM_W-1:0];
                        end
                    end
                    KIND_LINF: begin
                        w_alu_req.op = ALU_SUB;
                        if (w_alu_res[SUM_W]) begin
                            n_sum = r_term;
                        end
                    end
                    default: begin
                    end
                endcase
                n_rem  = '0;
                n_root = '0;
                n_cnt  = CNT_W'(ROOT_W - 1);
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (w_kind == KIND_L2) begin
                    n_state = ST_ROOT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ROOT: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = SUM_W'(w_rem_sh);
                w_alu_req.b  = SUM_W'(w_trial);
                if (!w_alu_res[SUM_W]) begin
                    n_rem  = w_alu_res[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_rem_sh;
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    unique case (w_kind) inside
                        KIND_L1, KIND_LINF: begin
                            if (r_sum[SUM_W-1:NORM_W] != '0) begin
                                n_norm = NORM_MAX;
                                n_ovf  = 1'b1;
                            end else begin
                                n_norm = r_sum[NORM_W-1:0];
                                n_ovf  = r_sat;
                            end
                        end
                        KIND_L2: begin
                            n_norm = NORM_W'(r_root);
                            n_ovf  = r_sat;
                        end
                        default: begin
                            n_norm = '0;
                            n_ovf  = 1'b0;
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_sat       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_norm_value = r_norm;
    assign o_overflow   = r_ovf;

endmodule

>>> rtl/vnorm_alu.sv
// ----------------------------------------------------------------------------
// vnorm_alu
// Shared 64-bit add/subtract unit with carry/borrow out. Used for the
// running sum, the maximum compare and every square root step.
// ----------------------------------------------------------------------------
module vnorm_alu (
    input  vnorm_pkg::t_alu_req            i_req,
    output logic [vnorm_pkg::SUM_W:0]      o_result
);
    import vnorm_pkg::*;

    always_comb begin
        if (i_req.op == ALU_SUB) begin
            o_result = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            o_result = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

endmodule

>>> rtl/vnorm_apb.sv
// ----------------------------------------------------------------------------
// vnorm_apb
// Configuration register file: holds the norm kind behind an APB-style
// port. Only the register at byte address 0 exists; address bit 2 alone is decoded,
// so addresses 1 to 3 alias it, and writes with bit 2 set are dropped.
module vnorm_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vnorm_pkg::APB_AW-1:0]   paddr,
    input  logic [vnorm_pkg::APB_DW-1:0]   pwdata,
    output logic [vnorm_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    output vnorm_pkg::t_norm_kind          o_norm_kind
);
    import vnorm_pkg::*;

    t_norm_kind r_norm_kind;
    logic       w_sel_kind;

    assign w_sel_kind = (paddr[APB_AW-1] == 1'b0);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_kind <= KIND_L2;
        end else if (psel && penable && pwrite && w_sel_kind) begin
            r_norm_kind <= t_norm_kind'(pwdata[1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_kind) begin
            prdata = {{(APB_DW-2){1'b0}}, r_norm_kind};
        end
    end

    assign o_norm_kind = r_norm_kind;

endmodule

>>> tb/tb_vector_norm_l1_l2_linf.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_norm_l1_l2_linf
// Self-checking bench for the streaming L1 / L2 / L-infinity norm block.
// A short directed table covers the element extremes, every norm kind, sum
// saturation, kind switches inside a vector and an unmapped register write.
// It is followed by random vectors that are checked against a behavioral
// model of the accumulator. Both channels are paced in bursts and stalls.
// ----------------------------------------------------------------------------
module tb_vector_norm_l1_l2_linf;
    import vnorm_pkg::*;

    localparam int REG_NORM_KIND = 0;
    localparam int REG_UNMAPPED  = 1;
    localparam int RAND_WORDS    = 1350;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 300;

    typedef enum {CFG_NONE, CFG_KIND, CFG_BAD} t_cfg_op;

    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic              ovf;
    } t_norm_res;

    typedef struct {
        t_cfg_op           op;
        t_norm_kind        kind;
        logic [ELEM_W-1:0] elem;
        logic              last;
        logic              typed;
        logic [NORM_W-1:0] norm;
        logic              ovf;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [ELEM_W-1:0] i_element_value;
    logic                 i_is_last;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [NORM_W-1:0]    o_norm_value;
    logic                 o_overflow;

    // sideband that travels with each word: hand-typed expected norm
    logic                 tag_typed;
    logic [NORM_W-1:0]    tag_norm;
    logic                 tag_ovf;

    t_norm_kind           pred_kind;
    logic [SUM_W-1:0]     acc_sum;
    logic                 acc_sat;
    t_norm_res            norm_q[$];
    t_dir_row             dir_rows[$];

    int  fail_count  = 0;
    int  words_in    = 0;
    int  norms_seen  = 0;
    int  sat_norms   = 0;
    int  kind_hits[4];
    int  mid_changes = 0;
    int  burst_left  = 0;
    bit  hold_req    = 1'b0;
    bit  hold_done   = 1'b0;

    vector_norm_l1_l2_linf dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .i_is_last       (i_is_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_norm_value    (o_norm_value),
        .o_overflow      (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [ROOT_W-1:0] isqrt64(input logic [SUM_W-1:0] x);
        logic [ROOT_W-1:0] r;
        logic [SUM_W-1:0]  t;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            t = {32'd0, r | (32'd1 << b)};
            if (t * t <= x) r = r | (32'd1 << b);
        end
        return r;
    endfunction

    task automatic fold_word(input logic [ELEM_W-1:0] v, input logic last,
                             output logic has, output t_norm_res r);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] sq;
        logic [SUM_W-1:0] cap;
        cap = {16'd0, NORM_MAX};
        mag = v[ELEM_W-1] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        sq  = mag * mag;
        has = last;
        r   = '0;
        case (pred_kind)
            KIND_L1: begin
                if (acc_sum > cap || cap - acc_sum < mag) begin
                    acc_sum = cap;
                    acc_sat = 1'b1;
                end else begin
                    acc_sum = acc_sum + mag;
                end
            end
            KIND_L2: begin
                if (SUM_MAX - acc_sum < sq) begin
                    acc_sum = SUM_MAX;
                    acc_sat = 1'b1;
                end else begin
                    acc_sum = acc_sum + sq;
                end
            end
            KIND_LINF: begin
                if (mag > acc_sum) acc_sum = mag;
            end
            default: ;
        endcase
        if (last) begin
            case (pred_kind) inside
                KIND_L1, KIND_LINF: begin
                    r.ovf = acc_sat;
                    if (acc_sum > cap) begin
                        r.norm = NORM_MAX;
                        r.ovf  = 1'b1;
                    end else begin
                        r.norm = acc_sum[NORM_W-1:0];
                    end
                end
                KIND_L2: begin
                    r.norm = {16'd0, isqrt64(acc_sum)};
                    r.ovf  = acc_sat;
                end
                default: ;
            endcase
            acc_sum = '0;
            acc_sat = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        logic      has;
        t_norm_res res;
        t_norm_res want;
        if (!i_rst_n) begin
            acc_sum <= '0;
            acc_sat <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                words_in++;
                fold_word(i_element_value, i_is_last, has, res);
                if (has) begin
                    kind_hits[int'(pred_kind)]++;
                    if (tag_typed) begin
                        res.norm = tag_norm;
                        res.ovf  = tag_ovf;
                    end
                    if (res.ovf) sat_norms++;
                    norm_q.push_back(res);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (norm_q.size() == 0) begin
                    $error("norm word with nothing expected: norm_value %h overflow %b",
                           o_norm_value, o_overflow);
                    fail_count++;
                end else begin
                    want = norm_q.pop_front();
                    norms_seen++;
                    if (o_norm_value !== want.norm) begin
                        $error("norm_value: expected %h, got %h", want.norm, o_norm_value);
                        fail_count++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %b, got %b", want.ovf, o_overflow);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic apb_write(input int idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_kind();
        logic [APB_DW-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(REG_NORM_KIND * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (data[1:0] !== pred_kind) begin
            $error("norm_kind readback: expected %0d, got %0d", pred_kind, data[1:0]);
            fail_count++;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (norm_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_kind(input t_norm_kind k);
        logic [APB_DW-1:0] data;
        drain_results();
        data      = $urandom;
        data[1:0] = k;
        apb_write(REG_NORM_KIND, data);
        pred_kind = k;
        check_kind();
    endtask

    task automatic offer_word(input logic [ELEM_W-1:0] v, input logic last,
                              input logic typed = 1'b0,
                              input logic [NORM_W-1:0] n = '0, input logic o = 1'b0);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_element_value <= v;
        i_is_last       <= last;
        tag_typed       <= typed;
        tag_norm        <= n;
        tag_ovf         <= o;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic [ELEM_W-1:0] pick_element();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(0, 9)) inside
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            4, 5: begin
                v = $urandom_range(0, 32'h0003_FFFF);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_norm_kind pick_kind();
        int r;
        r = $urandom_range(0, 6);
        if (r < 2) return KIND_L1;
        if (r < 4) return KIND_L2;
        if (r < 6) return KIND_LINF;
        return KIND_ZERO;
    endfunction

    task automatic add_row(input t_cfg_op op, input t_norm_kind k, input logic [ELEM_W-1:0] v,
                           input logic last, input logic typed = 1'b0,
                           input logic [NORM_W-1:0] n = '0, input logic o = 1'b0);
        t_dir_row row;
        row.op    = op;
        row.kind  = k;
        row.elem  = v;
        row.last  = last;
        row.typed = typed;
        row.norm  = n;
        row.ovf   = o;
        dir_rows.push_back(row);
    endtask

    // receiver: own stall pattern, plus one long hold on request
    initial begin
        int span;
        int mode;
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 120);
                for (n = 0; n < span; n++) begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= 1'($urandom_range(0, 1));
                        2: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default: i_out_stall <= n[0];
                    endcase
                    @(posedge i_clk);
                    if (hold_req && !hold_done) break;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int rand_words;
        int seg;
        int nvec;
        int len;
        int split;
        logic last;
        logic [ELEM_W-1:0] v;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_element_value <= '0;
        i_is_last       <= 1'b0;
        tag_typed       <= 1'b0;
        tag_norm        <= '0;
        tag_ovf         <= 1'b0;
        pred_kind        = KIND_L2;
        foreach (kind_hits[k]) kind_hits[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_kind();

        // reset kind is euclidean
        add_row(CFG_NONE, KIND_L2,   32'h0001_0000, 1'b1, 1'b1, 48'h0000_0001_0000, 1'b0);
        add_row(CFG_NONE, KIND_L2,   32'h8000_0000, 1'b1, 1'b1, 48'h0000_8000_0000, 1'b0);
        add_row(CFG_NONE, KIND_L2,   32'h0000_0000, 1'b1, 1'b1, 48'h0, 1'b0);
        add_row(CFG_NONE, KIND_L2,   32'h8000_0000, 1'b0);
        add_row(CFG_NONE, KIND_L2,   32'h8000_0000, 1'b0);
        add_row(CFG_NONE, KIND_L2,   32'h8000_0000, 1'b0);
        add_row(CFG_NONE, KIND_L2,   32'h8000_0000, 1'b1, 1'b1, 48'h0000_FFFF_FFFF, 1'b1);
        add_row(CFG_KIND, KIND_L1,   32'h8000_0000, 1'b1, 1'b1, 48'h0000_8000_0000, 1'b0);
        add_row(CFG_NONE, KIND_L1,   32'h7FFF_FFFF, 1'b0);
        add_row(CFG_NONE, KIND_L1,   32'hFFFF_FFFF, 1'b1, 1'b1, 48'h0000_8000_0000, 1'b0);
        add_row(CFG_KIND, KIND_LINF, 32'h0000_0005, 1'b0);
        add_row(CFG_NONE, KIND_LINF, 32'h8000_0000, 1'b0);
        add_row(CFG_NONE, KIND_LINF, 32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0000_8000_0000, 1'b0);
        add_row(CFG_KIND, KIND_ZERO, 32'h7FFF_FFFF, 1'b0);
        add_row(CFG_NONE, KIND_ZERO, 32'h1234_5678, 1'b1, 1'b1, 48'h0, 1'b0);
        // squared sum read out as a magnitude clamps, then an unmapped write leaves the kind
        add_row(CFG_KIND, KIND_L2,   32'h8000_0000, 1'b0);
        add_row(CFG_KIND, KIND_LINF, 32'h0000_0001, 1'b1, 1'b1, NORM_MAX, 1'b1);
        add_row(CFG_KIND, KIND_L2,   32'h8000_0000, 1'b0);
        add_row(CFG_KIND, KIND_L1,   32'h0001_0000, 1'b1, 1'b1, NORM_MAX, 1'b1);
        add_row(CFG_BAD,  KIND_ZERO, 32'h0000_0003, 1'b1, 1'b1, 48'h0000_0000_0003, 1'b0);
        add_row(CFG_NONE, KIND_L1,   32'h0002_0000, 1'b0);
        add_row(CFG_KIND, KIND_L2,   32'h0001_0000, 1'b1);
        add_row(CFG_NONE, KIND_L2,   32'h0001_8000, 1'b1);
        add_row(CFG_KIND, KIND_L1,   32'hFFFE_8000, 1'b0);
        add_row(CFG_KIND, KIND_LINF, 32'h0000_7FFF, 1'b1);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == CFG_KIND) begin
                set_kind(dir_rows[r].kind);
            end else if (dir_rows[r].op == CFG_BAD) begin
                drain_results();
                apb_write(REG_UNMAPPED, {$urandom} | APB_DW'(dir_rows[r].kind));
                check_kind();
            end
            offer_word(dir_rows[r].elem, dir_rows[r].last, dir_rows[r].typed,
                       dir_rows[r].norm, dir_rows[r].ovf);
        end

        rand_words = 0;
        seg = 0;
        while (rand_words < RAND_WORDS) begin
            set_kind(seg < 4 ? t_norm_kind'(seg[1:0]) : pick_kind());
            if (seg == 5) hold_req = 1'b1;
            nvec = $urandom_range(2, 12);
            repeat (nvec) begin
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 6);
                split = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : 0;
                for (int i = 0; i < len; i++) begin
                    if (split != 0 && i == split - 1 && i != 0) begin
                        set_kind(pick_kind());
                        mid_changes++;
                    end
                    last = (i == len - 1);
                    v = pick_element();
                    rand_words++;
                    offer_word(v, last);
                end
            end
            seg++;
        end

        drain_results();
        $display("words in %0d, norms checked %0d (L1 %0d, L2 %0d, Linf %0d, zero %0d)",
                 words_in, norms_seen, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
        $display("saturated norms %0d, kind switches inside a vector %0d, long hold %0d",
                 sat_norms, mid_changes, hold_done);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
